@@ rtl/waypoint_tracker_unit_assert.svh @@
// Assertion macros for the waypoint tracker checker.
// Used by the bound port checker only.
`ifndef WAYPOINT_TRACKER_UNIT_ASSERT_SVH
`define WAYPOINT_TRACKER_UNIT_ASSERT_SVH
`define WTU_ASSERT_IMPL(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define WTU_ASSERT_NORST(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`endif

@@ rtl/wpt_pkg.sv @@
// Package for the waypoint tracker: payload types, codes, constants.
// No dependencies.
`default_nettype none
package wpt_pkg;
  localparam int TableDepth = 32;
  localparam int IdxW = 5;
  localparam int CntW = 6;
  localparam int CordicSteps = 16;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_TRACK  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_RADIUS_NORMAL = 2'd0,
    CFG_RADIUS_TYPE1  = 2'd1,
    CFG_RADIUS_GARAGE = 2'd2,
    CFG_SLOW_DISTANCE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_FAR     = 2'd0,
    ST_SLOW    = 2'd1,
    ST_ARRIVED = 2'd2,
    ST_UNUSED  = 2'd3
  } arrival_t;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_SPECIAL = 2'd1,
    CLS_GARAGE = 2'd2,
    CLS_UNUSED = 2'd3
  } wp_class_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_SQ, S_SUM, S_ITER, S_DECIDE, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] pos_north;
    logic signed [23:0] pos_east;
    logic signed [15:0] heading_now;
    logic [7:0]         wp_type;
  } in_req_t;

  typedef struct packed {
    logic [24:0]        distance;
    logic signed [15:0] heading_error;
    logic [1:0]         arrival_status;
    logic               finished;
    logic [5:0]         stored_count;
    logic [5:0]         target_index;
  } out_req_t;

  typedef struct packed {
    logic capture;
    logic rd_entry;
    logic load;
    logic square;
    logic sum;
    logic iter;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
  } dp_sts_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
        5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
        5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
        5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
        5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
        5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
        5'd14: v = 32'd41721;     5'd15: v = 32'd20860;
        5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
        5'd18: v = 32'd2607;      5'd19: v = 32'd1303;
        5'd20: v = 32'd651;       5'd21: v = 32'd325;
        5'd22: v = 32'd162;       5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/wpt_ctrl.sv @@
// Controller for the waypoint tracker: sequences one request at a time.
// Depends on wpt_pkg.
`default_nettype none
module wpt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire wpt_pkg::dp_sts_t sts,
  output wpt_pkg::dp_cmd_t     cmd
);
  wpt_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      wpt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = wpt_pkg::S_READ;
        end
      end
      wpt_pkg::S_READ: begin
        cmd.rd_entry = 1'b1;
        state_nxt = wpt_pkg::S_LOAD;
      end
      wpt_pkg::S_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = wpt_pkg::S_SQ;
      end
      wpt_pkg::S_SQ: begin
        cmd.square = 1'b1;
        state_nxt = wpt_pkg::S_SUM;
      end
      wpt_pkg::S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = wpt_pkg::S_ITER;
      end
      wpt_pkg::S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_done) begin
          state_nxt = wpt_pkg::S_DECIDE;
        end
      end
      wpt_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = wpt_pkg::S_OUT;
      end
      wpt_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = wpt_pkg::S_IDLE;
        end
      end
      default: state_nxt = wpt_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/wpt_datapath.sv @@
// Datapath for the waypoint tracker: waypoint table, square root, CORDIC.
// Depends on wpt_pkg.
`default_nettype none
module wpt_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wpt_pkg::in_req_t in_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_sel,
  input  wire logic [15:0]      cfg_val,
  input  wire wpt_pkg::dp_cmd_t cmd,
  output wpt_pkg::dp_sts_t      sts,
  output wpt_pkg::out_req_t     out_data
);
  logic [23:0] mem_n [wpt_pkg::TableDepth];
  logic [23:0] mem_e [wpt_pkg::TableDepth];
  logic [15:0] mem_h [wpt_pkg::TableDepth];
  logic [1:0]  mem_c [wpt_pkg::TableDepth];

  logic [15:0] rad_n_r, rad_1_r, rad_g_r, slow_r;
  logic [5:0]  count_r, count_nxt, tgt_r, tgt_nxt;
  logic        done_r, done_nxt;
  wpt_pkg::in_req_t req_r;
  logic [23:0] rn_r, re_r;
  logic [15:0] rh_r;
  logic [1:0]  rc_r;
  logic        has_tgt_r;
  logic signed [24:0] dn_r, de_r;
  logic [49:0] sqn_r, sqe_r;
  logic [25:0] root_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [4:0]  step_r;
  wpt_pkg::out_req_t out_r;
  wpt_pkg::wp_class_t new_cls;

  logic signed [33:0] xs, ys;
  logic [31:0] zrnd;
  logic [15:0] desired;
  logic [15:0] rad;
  logic [24:0] dist_val;

  assign new_cls = (req_r.wp_type == 8'd1) ? wpt_pkg::CLS_SPECIAL :
                   (req_r.wp_type == 8'd2) ? wpt_pkg::CLS_GARAGE : wpt_pkg::CLS_NORMAL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_n_r <= 16'd819;
      rad_1_r <= 16'd512;
      rad_g_r <= 16'd307;
      slow_r  <= 16'd2048;
    end else if (cfg_we) begin
      case (wpt_pkg::cfg_idx_t'(cfg_sel))
        wpt_pkg::CFG_RADIUS_NORMAL: rad_n_r <= cfg_val;
        wpt_pkg::CFG_RADIUS_TYPE1:  rad_1_r <= cfg_val;
        wpt_pkg::CFG_RADIUS_GARAGE: rad_g_r <= cfg_val;
        wpt_pkg::CFG_SLOW_DISTANCE: slow_r  <= cfg_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_entry && req_r.func == wpt_pkg::FUNC_RECORD &&
        count_r < 6'(wpt_pkg::TableDepth)) begin
      mem_n[count_r[4:0]] <= req_r.pos_north;
      mem_e[count_r[4:0]] <= req_r.pos_east;
      mem_h[count_r[4:0]] <= req_r.heading_now;
      mem_c[count_r[4:0]] <= new_cls;
    end
    rn_r <= mem_n[tgt_r[4:0]];
    re_r <= mem_e[tgt_r[4:0]];
    rh_r <= mem_h[tgt_r[4:0]];
    rc_r <= mem_c[tgt_r[4:0]];
  end

  always_comb begin
    xs = cx_r >>> step_r;
    ys = cy_r >>> step_r;
    zrnd = 32'(cz_r) + 32'h8000;
    desired = (rc_r == wpt_pkg::CLS_SPECIAL || rc_r == wpt_pkg::CLS_GARAGE) ?
              rh_r : zrnd[31:16];
    rad = (rc_r == wpt_pkg::CLS_SPECIAL) ? rad_1_r :
          (rc_r == wpt_pkg::CLS_GARAGE) ? rad_g_r : rad_n_r;
    dist_val = root_r[24:0];
  end

  // square root: one result bit per step over 26 bit pairs
  logic [5:0] sq_step_r;
  logic [101:0] sq_val_r;
  logic [52:0] sq_rem_r;
  logic [52:0] sq_try;
  assign sq_try = {sq_rem_r[50:0], sq_val_r[101:100]} - {25'd0, root_r, 2'b01};
  assign sts.iter_done = (sq_step_r == 6'd25) && (step_r >= 5'(wpt_pkg::CordicSteps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tgt_r <= '0;
      done_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      tgt_r <= tgt_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    tgt_nxt = tgt_r;
    done_nxt = done_r;
    if (cmd.rd_entry) begin
      case (wpt_pkg::func_t'(req_r.func))
        wpt_pkg::FUNC_RECORD:
          if (count_r < 6'(wpt_pkg::TableDepth)) count_nxt = count_r + 6'd1;
        wpt_pkg::FUNC_TRACK:
          if (tgt_r >= count_r) done_nxt = 1'b1;
        wpt_pkg::FUNC_CLEAR: begin
          count_nxt = '0;
          tgt_nxt = '0;
          done_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd.decide && has_tgt_r && dist_val < 25'(rad)) begin
      tgt_nxt = tgt_r + 6'd1;
      if (tgt_r + 6'd1 >= count_r) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.rd_entry) begin
      has_tgt_r <= (req_r.func == wpt_pkg::FUNC_TRACK) && (tgt_r < count_r);
      out_r.distance <= '0;
      out_r.heading_error <= '0;
      out_r.arrival_status <= (req_r.func == wpt_pkg::FUNC_TRACK && tgt_r >= count_r) ?
                              wpt_pkg::ST_ARRIVED : wpt_pkg::ST_FAR;
      out_r.finished <= 1'b0;
      out_r.stored_count <= (req_r.func == wpt_pkg::FUNC_RECORD &&
                             count_r >= 6'(wpt_pkg::TableDepth)) ? 6'd0 : count_nxt;
      out_r.target_index <= '0;
    end
    if (cmd.load) begin
      dn_r <= 25'(signed'(rn_r)) - 25'(req_r.pos_north);
      de_r <= 25'(signed'(re_r)) - 25'(req_r.pos_east);
    end
    if (cmd.square) begin
      sqn_r <= 50'(dn_r * dn_r);
      sqe_r <= 50'(de_r * de_r);
      if (dn_r < 0) begin
        if (de_r >= 0) begin
          cx_r <= 34'(de_r); cy_r <= -34'(dn_r); cz_r <= 34'sd1073741824;
        end else begin
          cx_r <= -34'(de_r); cy_r <= 34'(dn_r); cz_r <= -34'sd1073741824;
        end
      end else begin
        cx_r <= 34'(dn_r); cy_r <= 34'(de_r); cz_r <= '0;
      end
      step_r <= '0;
    end
    if (cmd.sum) begin
      sq_val_r <= {51'd0, 51'(sqn_r) + 51'(sqe_r)} << 50;
      sq_rem_r <= '0;
      root_r <= '0;
      sq_step_r <= '0;
    end
    if (cmd.iter) begin
      if (sq_step_r < 6'd26) begin
        if (!sq_try[52]) begin
          sq_rem_r <= sq_try;
          root_r <= {root_r[24:0], 1'b1};
        end else begin
          sq_rem_r <= {sq_rem_r[50:0], sq_val_r[101:100]};
          root_r <= {root_r[24:0], 1'b0};
        end
        sq_val_r <= sq_val_r << 2;
        sq_step_r <= sq_step_r + 6'd1;
      end
      if (step_r < 5'(wpt_pkg::CordicSteps)) begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs;
          cz_r <= cz_r + 34'(wpt_pkg::atan_val(step_r));
        end else begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs;
          cz_r <= cz_r - 34'(wpt_pkg::atan_val(step_r));
        end
        step_r <= step_r + 5'd1;
      end
    end
    if (cmd.decide) begin
      if (has_tgt_r) begin
        out_r.distance <= dist_val;
        out_r.heading_error <= desired - req_r.heading_now;
        out_r.arrival_status <= (dist_val < 25'(rad)) ? wpt_pkg::ST_ARRIVED :
                                (dist_val < 25'(slow_r)) ? wpt_pkg::ST_SLOW : wpt_pkg::ST_FAR;
      end
      out_r.finished <= done_nxt;
      out_r.target_index <= tgt_nxt;
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

@@ rtl/waypoint_tracker_unit.sv @@
// Waypoint tracker: one request at a time. After acceptance the request passes
// through table read, subtract, square and sum stages, 26 square-root steps
// running alongside the 16-step CORDIC, then decide; the result then waits in an
// output register until taken, and the next request can be accepted in the
// cycle after the result is taken, so no new request is taken while a result
// is pending. Configuration is taken any cycle.
`default_nettype none
module waypoint_tracker_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wpt_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wpt_pkg::out_req_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  wpt_pkg::dp_cmd_t cmd;
  wpt_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  wpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  wpt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_we(cfg_valid & cfg_ready), .cfg_sel(cfg_index), .cfg_val(cfg_data),
    .cmd(cmd), .sts(sts), .out_data(out_data)
  );
endmodule
`default_nettype wire

@@ rtl/wpt_checker.sv @@
// Port checker for the waypoint tracker, bound to the top level.
// Depends on waypoint_tracker_unit_assert.svh.
`default_nettype none
`include "waypoint_tracker_unit_assert.svh"
module wpt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall
);
  `WTU_ASSERT_IMPL(a_no_overlap, clk, rst_n, (in_valid && !in_stall) |=> !out_valid, "result too early")
  `WTU_ASSERT_IMPL(a_busy, clk, rst_n, out_valid |-> in_stall, "input open while result held")
  `WTU_ASSERT_IMPL(a_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped")
  `WTU_ASSERT_NORST(a_rst, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule
bind waypoint_tracker_unit wpt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall)
);
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for waypoint_tracker_unit: record, track and clear
// requests are checked against a behavioral predictor of the tracker.
// Depends on rtl/wpt_pkg.sv and rtl/waypoint_tracker_unit.sv.
`timescale 1ns / 1ps
module testbench;
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  wpt_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  wpt_pkg::out_req_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  waypoint_tracker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int CycleLimit = 2000000;

  logic [15:0] rad_normal, rad_special, rad_garage, slow_dist;
  logic signed [23:0] wp_north [wpt_pkg::TableDepth];
  logic signed [23:0] wp_east [wpt_pkg::TableDepth];
  logic [15:0] wp_heading [wpt_pkg::TableDepth];
  wpt_pkg::wp_class_t wp_class [wpt_pkg::TableDepth];
  int unsigned wp_count;
  int unsigned target_idx;
  logic done;

  wpt_pkg::out_req_t expected_q[$];
  int errors;
  int cycles;
  int long_hold;
  int burst_left;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] bearing(input longint y, input longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    logic [31:0] zz;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 1073741824;
      end else begin
        t = x; x = -y; y = t; z = -1073741824;
      end
    end
    for (int i = 0; i < wpt_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(wpt_pkg::atan_val(i[4:0]));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(wpt_pkg::atan_val(i[4:0]));
      end
    end
    zz = z[31:0];
    zz = zz + 32'h8000;
    return zz[31:16];
  endfunction

  function automatic wpt_pkg::out_req_t track_step(input wpt_pkg::in_req_t r);
    wpt_pkg::out_req_t o;
    longint dn;
    longint de;
    logic [63:0] sq;
    logic [63:0] d;
    logic [15:0] want;
    logic [15:0] rad;
    wpt_pkg::wp_class_t c;
    bit refused;
    o = '0;
    refused = 0;
    case (wpt_pkg::func_t'(r.func))
      wpt_pkg::FUNC_RECORD: begin
        if (wp_count >= wpt_pkg::TableDepth) begin
          refused = 1;
        end else begin
          wp_north[wp_count] = r.pos_north;
          wp_east[wp_count] = r.pos_east;
          wp_heading[wp_count] = r.heading_now;
          wp_class[wp_count] = (r.wp_type == 8'd1) ? wpt_pkg::CLS_SPECIAL :
                               (r.wp_type == 8'd2) ? wpt_pkg::CLS_GARAGE :
                               wpt_pkg::CLS_NORMAL;
          wp_count++;
        end
      end
      wpt_pkg::FUNC_TRACK: begin
        if (target_idx >= wp_count) begin
          done = 1;
          o.arrival_status = wpt_pkg::ST_ARRIVED;
        end else begin
          c = wp_class[target_idx];
          dn = longint'(wp_north[target_idx]) - longint'(r.pos_north);
          de = longint'(wp_east[target_idx]) - longint'(r.pos_east);
          sq = dn * dn + de * de;
          d = int_sqrt(sq);
          want = (c == wpt_pkg::CLS_NORMAL) ? bearing(de, dn) : wp_heading[target_idx];
          o.distance = d[24:0];
          o.heading_error = want - r.heading_now;
          rad = (c == wpt_pkg::CLS_SPECIAL) ? rad_special :
                (c == wpt_pkg::CLS_GARAGE) ? rad_garage : rad_normal;
          if (d < rad) begin
            target_idx++;
            if (target_idx >= wp_count) done = 1;
            o.arrival_status = wpt_pkg::ST_ARRIVED;
          end else if (d < slow_dist) begin
            o.arrival_status = wpt_pkg::ST_SLOW;
          end else begin
            o.arrival_status = wpt_pkg::ST_FAR;
          end
        end
      end
      wpt_pkg::FUNC_CLEAR: begin
        wp_count = 0;
        target_idx = 0;
        done = 0;
      end
      default: ;
    endcase
    o.finished = done;
    o.stored_count = refused ? 6'd0 : wp_count[5:0];
    o.target_index = target_idx[5:0];
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall pattern, with an occasional long hold
  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0) && (cycles % 512 < 300);
    end
  end

  always @(posedge clk) begin
    wpt_pkg::out_req_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.distance !== e.distance) begin
          $error("distance exp %0d got %0d", e.distance, out_data.distance); errors++;
        end
        if (out_data.heading_error !== e.heading_error) begin
          $error("heading_error exp %0d got %0d", e.heading_error,
                 out_data.heading_error); errors++;
        end
        if (out_data.arrival_status !== e.arrival_status) begin
          $error("arrival_status exp %0d got %0d", e.arrival_status,
                 out_data.arrival_status); errors++;
        end
        if (out_data.finished !== e.finished) begin
          $error("finished exp %0d got %0d", e.finished, out_data.finished); errors++;
        end
        if (out_data.stored_count !== e.stored_count) begin
          $error("stored_count exp %0d got %0d", e.stored_count,
                 out_data.stored_count); errors++;
        end
        if (out_data.target_index !== e.target_index) begin
          $error("target_index exp %0d got %0d", e.target_index,
                 out_data.target_index); errors++;
        end
      end
    end
  end

  task automatic send_req(input wpt_pkg::in_req_t r, input bit gappy);
    if (gappy) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(0, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(track_step(r));
    @(negedge clk);
    in_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input wpt_pkg::cfg_idx_t idx, input logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wpt_pkg::CFG_RADIUS_NORMAL: rad_normal = v;
      wpt_pkg::CFG_RADIUS_TYPE1: rad_special = v;
      wpt_pkg::CFG_RADIUS_GARAGE: rad_garage = v;
      default: slow_dist = v;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic wpt_pkg::in_req_t make_req(input wpt_pkg::func_t f, input int n,
                                                input int e, input int h, input int t);
    wpt_pkg::in_req_t r;
    r.func = f;
    r.pos_north = n[23:0];
    r.pos_east = e[23:0];
    r.heading_now = h[15:0];
    r.wp_type = t[7:0];
    return r;
  endfunction

  function automatic int rnd_pos();
    logic [23:0] v;
    v = 24'($urandom());
    case ($urandom_range(0, 3))
      0: return int'(v);
      1: return int'(signed'(v));
      default: return int'($urandom_range(0, 8000)) - 4000;
    endcase
  endfunction

  task automatic test_directed();
    send_req(make_req(wpt_pkg::FUNC_TRACK, 0, 0, 0, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_NONE, 5, 5, 5, 5), 0);
    send_req(make_req(wpt_pkg::FUNC_RECORD, 8388607, -8388608, -32768, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_RECORD, -8388608, 8388607, 32767, 1), 0);
    send_req(make_req(wpt_pkg::FUNC_RECORD, 0, 0, 100, 2), 0);
    send_req(make_req(wpt_pkg::FUNC_RECORD, 1000, -1000, 0, 255), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, -8388608, 8388607, 32767, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, 8388607, -8388608, -32768, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, 8388607, -8388607, 0, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, -8388608, 8388607, 0, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, 1500, 0, 0, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, 0, 0, -5, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, 1000, -1000, 0, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_TRACK, 1, 1, 0, 0), 0);
    send_req(make_req(wpt_pkg::FUNC_RECORD, 3, 3, 3, 3), 0);
    send_req(make_req(wpt_pkg::FUNC_CLEAR, 0, 0, 0, 0), 0);
    for (int i = 0; i < 33; i++)
      send_req(make_req(wpt_pkg::FUNC_RECORD, -i * 100, i * 50, i, i % 4), 0);
    send_req(make_req(wpt_pkg::FUNC_CLEAR, 0, 0, 0, 0), 0);
    drain();
  endtask

  task automatic test_routes(input int n_items);
    int sent;
    int len;
    int k;
    wpt_pkg::in_req_t r;
    sent = 0;
    while (sent < n_items) begin
      send_req(make_req(wpt_pkg::FUNC_CLEAR, 0, 0, 0, 0), 1);
      len = $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) len = 34;
      for (int i = 0; i < len; i++) begin
        r = make_req(wpt_pkg::FUNC_RECORD, rnd_pos(), rnd_pos(), int'($urandom()),
                     int'($urandom_range(0, 4)));
        if ($urandom_range(0, 7) == 0) r.wp_type = 8'($urandom());
        send_req(r, 1);
        sent++;
      end
      for (int i = 0; i < len + 4; i++) begin
        k = (target_idx < wp_count) ? target_idx : 0;
        r.func = wpt_pkg::FUNC_TRACK;
        r.heading_now = 16'($urandom());
        r.wp_type = 8'($urandom());
        case ($urandom_range(0, 4))
          0: begin
            r.pos_north = 24'(rnd_pos());
            r.pos_east = 24'(rnd_pos());
          end
          1: begin
            r.pos_north = 24'(int'(wp_north[k]) + int'($urandom_range(0, 6000)) - 3000);
            r.pos_east = 24'(int'(wp_east[k]) + int'($urandom_range(0, 6000)) - 3000);
          end
          default: begin
            r.pos_north = 24'(int'(wp_north[k]) + int'($urandom_range(0, 800)) - 400);
            r.pos_east = 24'(int'(wp_east[k]) + int'($urandom_range(0, 800)) - 400);
          end
        endcase
        if ($urandom_range(0, 19) == 0) r.func = wpt_pkg::func_t'($urandom_range(0, 3));
        send_req(r, 1);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    long_hold = 300;
    for (int i = 0; i < 12; i++)
      send_req(make_req(wpt_pkg::FUNC_RECORD, rnd_pos(), rnd_pos(), int'($urandom()),
                        i % 3), 0);
    drain();
    send_req(make_req(wpt_pkg::FUNC_TRACK, 0, 0, 0, 0), 0);
    drain();
  endtask

  task automatic test_config();
    write_reg(wpt_pkg::CFG_RADIUS_NORMAL, 16'hFFFF);
    write_reg(wpt_pkg::CFG_RADIUS_TYPE1, 16'd0);
    write_reg(wpt_pkg::CFG_RADIUS_GARAGE, 16'hFFFF);
    write_reg(wpt_pkg::CFG_SLOW_DISTANCE, 16'hFFFF);
    test_routes(150);
    drain();
    write_reg(wpt_pkg::CFG_RADIUS_NORMAL, 16'd0);
    write_reg(wpt_pkg::CFG_RADIUS_TYPE1, 16'hFFFF);
    write_reg(wpt_pkg::CFG_RADIUS_GARAGE, 16'd0);
    write_reg(wpt_pkg::CFG_SLOW_DISTANCE, 16'd0);
    test_routes(150);
    drain();
    write_reg(wpt_pkg::CFG_RADIUS_NORMAL, 16'd300);
    write_reg(wpt_pkg::CFG_RADIUS_TYPE1, 16'd200);
    write_reg(wpt_pkg::CFG_RADIUS_GARAGE, 16'd100);
    write_reg(wpt_pkg::CFG_SLOW_DISTANCE, 16'd1500);
    test_routes(150);
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = wpt_pkg::CFG_RADIUS_NORMAL;
    cfg_data = 0;
    errors = 0;
    cycles = 0;
    long_hold = 0;
    burst_left = 0;
    rad_normal = 819;
    rad_special = 512;
    rad_garage = 307;
    slow_dist = 2048;
    wp_count = 0;
    target_idx = 0;
    done = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_routes(300);
    drain();
    test_backpressure();
    test_config();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
